// ----- rtl/rair_pkg.sv -----
// Shared types and codes for the ray versus axis-aligned rectangle test.
`timescale 1ns / 1ps
package rair_pkg;

  // Rectangle axis pair; the remaining axis is the plane normal.
  typedef enum logic [1:0] {
    AXIS_XY = 2'd0,
    AXIS_XZ = 2'd1,
    AXIS_YZ = 2'd2
  } axis_e;

  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_AXIS_PAIR   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FIRST_LOW   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FIRST_HIGH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SECOND_LOW  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SECOND_HIGH = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PLANE_OFS   = 3'd5;

  // Per-word flags that travel down the pipeline.
  typedef struct packed {
    logic vld;
    logic miss;
  } flag_t;

endpackage

// ----- rtl/rair_divpipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
`timescale 1ns / 1ps
module rair_divpipe #(
  parameter int NW = 49,
  parameter int DW = 32,
  parameter int QB = 31,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QB-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  // Caller guarantees num_i < den_i * 2^QB.
  localparam int W = DW + QB;

  logic          vld_q  [QB];
  logic [W-1:0]  rem_q  [QB-1];
  logic [DW-1:0] den_q  [QB-1];
  logic [QB-1:0] quo_q  [QB];
  logic [SW-1:0] side_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int B = QB - 1 - s;
    logic [W-1:0]  rem_in;
    logic [W-1:0]  dsh;
    logic [QB-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in  = W'(num_i);
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign dsh = W'(den_in) << B;
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[s]  <= quo_in | (QB'(ge) << B);
      side_q[s] <= side_in;
    end

    // The last stage needs no remainder or divisor.
    if (s < QB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[s] <= ge ? (rem_in - dsh) : rem_in;
        den_q[s] <= den_in;
      end
    end
  end

  assign valid_o = vld_q[QB-1];
  assign quot_o  = quo_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule

// ----- rtl/rair_point.sv -----
// Range check on t, then hit point origin + t*dir in two register stages.
`timescale 1ns / 1ps
module rair_point #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rair_pkg::flag_t                      flg_i,
  input  logic [COORD_BITS-2:0]                t_i,
  input  logic [COORD_BITS-2:0]                tmax_i,
  input  logic [2:0][COORD_BITS-1:0]           org_i,
  input  logic [2:0][COORD_BITS-1:0]           dir_i,
  output rair_pkg::flag_t                      flg_o,
  output logic [COORD_BITS-2:0]                t_o,
  output logic [2:0][COORD_BITS+1:0]           pnt_o
);

  localparam int C  = COORD_BITS;
  localparam int PW = 2 * C - 1;
  localparam int QW = PW - FRAC_BITS;

  rair_pkg::flag_t        flg1_q, flg2_q;
  logic [C-2:0]           t1_q, t2_q;
  logic [2:0][C-1:0]      org1_q;
  logic [2:0][PW-1:0]     prod_q;
  logic [2:0]             neg_q;
  logic [2:0][C+1:0]      pnt_q;

  logic [2:0][C-1:0]      mag;
  logic [2:0][C+1:0]      pnt_d;
  logic                   miss1;

  assign miss1 = flg_i.miss || (t_i == '0) || (t_i >= tmax_i);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = dir_i[k][C-1] ? (~dir_i[k] + 1'b1) : dir_i[k];
    end
  end

  // Scale, clamp the magnitude to 2^C, then apply sign and add the origin.
  always_comb begin
    logic [QW-1:0]         shq;
    logic [C:0]            clq;
    logic signed [C+1:0]   sq;
    for (int k = 0; k < 3; k++) begin
      shq = QW'(prod_q[k] >> FRAC_BITS);
      clq = (shq > (QW'(1) << C)) ? ((C+1)'(1) << C) : shq[C:0];
      sq  = neg_q[k] ? -$signed({1'b0, clq}) : $signed({1'b0, clq});
      pnt_d[k] = $signed({{2{org1_q[k][C-1]}}, org1_q[k]}) + sq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flg1_q <= '0;
      flg2_q <= '0;
    end else begin
      flg1_q <= '{vld: flg_i.vld, miss: miss1};
      flg2_q <= flg1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q   <= t_i;
    org1_q <= org_i;
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= PW'(t_i) * PW'(mag[k]);
      neg_q[k]  <= dir_i[k][C-1];
    end
    t2_q  <= t1_q;
    pnt_q <= pnt_d;
  end

  assign flg_o = flg2_q;
  assign t_o   = t2_q;
  assign pnt_o = pnt_q;

endmodule

// ----- rtl/ray_axis_rect_intersect_top.sv -----
// Top level: ray versus axis-aligned rectangle intersection pipeline.
`timescale 1ns / 1ps
// Takes one ray per clock on start_i and returns exactly one result on done_o
// for each ray, one per clock in order. Each ray passes the input register, the
// bit-per-stage crossing parameter divider (COORD_BITS - 1 stages), the hit
// point and bounds registers, the u,v dividers (UV_BITS stages) and the output
// register. busy_o is always low and the receiver cannot stall, so done_o must
// be taken when shown. When done_o is high and hit_o is low, t_hit_o, the hit
// point and u,v read zero; occluded_o is reported either way. Write the rectangle
// registers only while no ray is in flight.
module ray_axis_rect_intersect_top #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  parameter int UV_BITS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] origin_x_i,
  input  logic signed [COORD_BITS-1:0] origin_y_i,
  input  logic signed [COORD_BITS-1:0] origin_z_i,
  input  logic signed [COORD_BITS-1:0] dir_x_i,
  input  logic signed [COORD_BITS-1:0] dir_y_i,
  input  logic signed [COORD_BITS-1:0] dir_z_i,
  input  logic [COORD_BITS-2:0]        max_dist_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rair_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic                         occluded_o,
  output logic [COORD_BITS-2:0]        t_hit_o,
  output logic signed [COORD_BITS-1:0] hit_x_o,
  output logic signed [COORD_BITS-1:0] hit_y_o,
  output logic signed [COORD_BITS-1:0] hit_z_o,
  output logic [UV_BITS-1:0]           coord_u_o,
  output logic [UV_BITS-1:0]           coord_v_o
);

  localparam int C   = COORD_BITS;
  localparam int W2  = 2 * C - 1;
  localparam int TNW = C + 1 + FRAC_BITS;
  localparam int TSW = 7 * C;
  localparam int UNW = C + UV_BITS;
  localparam int USW = 4 * C;

  // ---------------- configuration registers ----------------
  logic [1:0]   axis_q;
  logic [C-1:0] fl_q, fh_q, sl_q, sh_q, po_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= 2'(rair_pkg::AXIS_XY);
      fl_q   <= '0;
      fh_q   <= C'(1) << FRAC_BITS;
      sl_q   <= '0;
      sh_q   <= C'(1) << FRAC_BITS;
      po_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rair_pkg::REG_AXIS_PAIR:   axis_q <= cfg_data_i[1:0];
        rair_pkg::REG_FIRST_LOW:   fl_q   <= cfg_data_i;
        rair_pkg::REG_FIRST_HIGH:  fh_q   <= cfg_data_i;
        rair_pkg::REG_SECOND_LOW:  sl_q   <= cfg_data_i;
        rair_pkg::REG_SECOND_HIGH: sh_q   <= cfg_data_i;
        rair_pkg::REG_PLANE_OFS:   po_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: plane numerator and denominator ----------------
  logic signed [C-1:0] oc, dc;
  logic                ax_ok;
  logic signed [C:0]   num;
  logic                miss0;

  always_comb begin
    ax_ok = 1'b1;
    unique case (rair_pkg::axis_e'(axis_q))
      rair_pkg::AXIS_XY: begin oc = origin_z_i; dc = dir_z_i; end
      rair_pkg::AXIS_XZ: begin oc = origin_y_i; dc = dir_y_i; end
      rair_pkg::AXIS_YZ: begin oc = origin_x_i; dc = dir_x_i; end
      default: begin oc = '0; dc = '0; ax_ok = 1'b0; end
    endcase
  end

  assign num   = $signed({po_q[C-1], po_q}) - $signed({oc[C-1], oc});
  assign miss0 = !ax_ok || (dc == '0) || (num == '0) || (num[C] != dc[C-1]);

  rair_pkg::flag_t     flg0_q;
  logic [C:0]          un_q;
  logic [C-1:0]        ud_q;
  logic [2:0][C-1:0]   org0_q, dir0_q;
  logic [C-2:0]        tmax0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flg0_q <= '0;
    end else begin
      flg0_q <= '{vld: start_i && !busy_o, miss: miss0};
    end
  end

  always_ff @(posedge clk_i) begin
    un_q    <= num[C] ? (C+1)'(-num) : (C+1)'(num);
    ud_q    <= dc[C-1] ? C'(-dc) : C'(dc);
    org0_q  <= {origin_z_i, origin_y_i, origin_x_i};
    dir0_q  <= {dir_z_i, dir_y_i, dir_x_i};
    tmax0_q <= max_dist_i;
  end

  // ---------------- t = (num << F) / den ----------------
  logic [TNW-1:0] tnum;
  logic           tovf;
  logic           tdv_vld;
  logic [C-2:0]   tdv_q;
  logic [TSW-1:0] tdv_side;

  assign tnum = {un_q, {FRAC_BITS{1'b0}}};
  // Drop quotients that do not fit the t field.
  assign tovf = W2'(tnum) >= (W2'(ud_q) << (C - 1));

  rair_divpipe #(
    .NW(TNW), .DW(C), .QB(C - 1), .SW(TSW)
  ) u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (flg0_q.vld),
    .num_i   (tnum),
    .den_i   (ud_q),
    .side_i  ({org0_q, dir0_q, tmax0_q, flg0_q.miss || tovf}),
    .valid_o (tdv_vld),
    .quot_o  (tdv_q),
    .side_o  (tdv_side)
  );

  // ---------------- hit point ----------------
  rair_pkg::flag_t    tflg;
  rair_pkg::flag_t    pflg;
  logic [C-2:0]       pt;
  logic [2:0][C+1:0]  pnt;

  assign tflg = '{vld: tdv_vld, miss: tdv_side[0]};

  rair_point #(
    .COORD_BITS(C), .FRAC_BITS(FRAC_BITS)
  ) u_point (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flg_i  (tflg),
    .t_i    (tdv_q),
    .tmax_i (tdv_side[C-1:1]),
    .org_i  (tdv_side[7*C-1:4*C]),
    .dir_i  (tdv_side[4*C-1:C]),
    .flg_o  (pflg),
    .t_o    (pt),
    .pnt_o  (pnt)
  );

  // ---------------- bounds test ----------------
  logic signed [C+1:0] pa, pb, flx, fhx, slx, shx;
  logic signed [C+1:0] da, db;
  logic [C-1:0]        dfu, dfv;
  logic                incl, strict;

  always_comb begin
    unique case (rair_pkg::axis_e'(axis_q))
      rair_pkg::AXIS_XY: begin pa = pnt[0]; pb = pnt[1]; end
      rair_pkg::AXIS_XZ: begin pa = pnt[0]; pb = pnt[2]; end
      rair_pkg::AXIS_YZ: begin pa = pnt[1]; pb = pnt[2]; end
      default:           begin pa = '0;     pb = '0;     end
    endcase
  end

  assign flx = $signed({{2{fl_q[C-1]}}, fl_q});
  assign fhx = $signed({{2{fh_q[C-1]}}, fh_q});
  assign slx = $signed({{2{sl_q[C-1]}}, sl_q});
  assign shx = $signed({{2{sh_q[C-1]}}, sh_q});

  assign incl   = (pa >= flx) && (pa <= fhx) && (pb >= slx) && (pb <= shx);
  assign strict = (pa > flx) && (pa < fhx) && (pb > slx) && (pb < shx);

  assign da  = pa - flx;
  assign db  = pb - slx;
  assign dfu = C'(fhx - flx);
  assign dfv = C'(shx - slx);

  logic         bvld_q, bhit_q, bocc_q;
  logic [C-2:0] bt_q;
  logic [2:0][C-1:0] bp_q;
  logic [C-1:0] nu_q, nv_q, du_q, dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q <= 1'b0;
    end else begin
      bvld_q <= pflg.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    bhit_q <= !pflg.miss && strict;
    bocc_q <= !pflg.miss && incl;
    bt_q   <= pt;
    for (int k = 0; k < 3; k++) begin
      bp_q[k] <= pnt[k][C-1:0];
    end
    nu_q <= da[C-1:0];
    nv_q <= db[C-1:0];
    du_q <= dfu;
    dv_q <= dfv;
  end

  // ---------------- u, v dividers ----------------
  logic              uvld, vvld;
  logic [UV_BITS-1:0] uq, vq;
  logic [USW-1:0]    uside;
  logic              vhit;

  rair_divpipe #(
    .NW(UNW), .DW(C), .QB(UV_BITS), .SW(USW)
  ) u_udiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bvld_q),
    .num_i   ({nu_q, {UV_BITS{1'b0}}}),
    .den_i   (du_q),
    .side_i  ({bp_q, bt_q, bocc_q}),
    .valid_o (uvld),
    .quot_o  (uq),
    .side_o  (uside)
  );

  rair_divpipe #(
    .NW(UNW), .DW(C), .QB(UV_BITS), .SW(1)
  ) u_vdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bvld_q),
    .num_i   ({nv_q, {UV_BITS{1'b0}}}),
    .den_i   (dv_q),
    .side_i  (bhit_q),
    .valid_o (vvld),
    .quot_o  (vq),
    .side_o  (vhit)
  );

  // ---------------- output register ----------------
  logic               ovld;
  logic               done_q, hit_q, occ_q;
  logic [C-2:0]       t_q;
  logic [2:0][C-1:0]  p_q;
  logic [UV_BITS-1:0] u_q, v_q;

  assign ovld = uvld && vvld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      occ_q  <= 1'b0;
    end else begin
      done_q <= ovld;
      hit_q  <= ovld && vhit;
      occ_q  <= ovld && uside[0];
    end
  end

  // Zero the result fields on a miss.
  always_ff @(posedge clk_i) begin
    t_q <= vhit ? uside[C-1:1] : '0;
    p_q <= vhit ? uside[4*C-1:C] : '0;
    u_q <= vhit ? uq : '0;
    v_q <= vhit ? vq : '0;
  end

  assign done_o     = done_q;
  assign hit_o      = hit_q;
  assign occluded_o = occ_q;
  assign t_hit_o    = t_q;
  assign hit_x_o    = p_q[0];
  assign hit_y_o    = p_q[1];
  assign hit_z_o    = p_q[2];
  assign coord_u_o  = u_q;
  assign coord_v_o  = v_q;

`ifndef ASSERT_OFF
  a_hit_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> (occluded_o && done_o))
    else $error("hit without occluded or done");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (t_hit_o == '0 && coord_u_o == '0 && coord_v_o == '0))
    else $error("miss result fields not zero");

  a_t_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> (t_hit_o != '0))
    else $error("hit with zero t");
`endif

endmodule

// ----- test/ray_axis_rect_intersect_top_tb.sv -----
// Testbench for the ray versus axis-aligned rectangle intersection pipeline.
`timescale 1ns / 1ps
module ray_axis_rect_intersect_top_tb;

  localparam longint unsigned TMAX_MASK = 64'h7FFF_FFFF;
  localparam longint unsigned PROD_CAP  = 64'h1_0000_0000;
  localparam int              DRAIN_CYC = 60;

  typedef struct {
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic [30:0]      max_dist;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic        occluded;
    logic [30:0] t_hit;
    logic [31:0] hx, hy, hz;
    logic [15:0] u, v;
  } isect_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic [30:0] max_dist_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rair_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic done_o, hit_o, occluded_o;
  logic [30:0] t_hit_o;
  logic signed [31:0] hit_x_o, hit_y_o, hit_z_o;
  logic [15:0] coord_u_o, coord_v_o;

  ray_axis_rect_intersect_top DUT (.*);

  initial forever #4 clk_i = ~clk_i;

  // shadow copy of the rectangle registers
  logic [1:0] rect_axes = rair_pkg::AXIS_XY;
  longint rect_a_lo = 0, rect_a_hi = 65536, rect_b_lo = 0, rect_b_hi = 65536;
  longint rect_plane = 0;

  isect_t pending_q[$];
  int errors = 0, rays_sent = 0, results_seen = 0, hits_seen = 0, occl_seen = 0;

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned frac_bits(longint unsigned n, longint unsigned d,
                                                int nb);
    longint unsigned q = 0;
    for (int i = 0; i < nb; i++) begin
      n = n << 1;
      q = q << 1;
      if (n >= d) begin
        n -= d;
        q |= 1;
      end
    end
    return q;
  endfunction

  // t*dir >> 16, truncated toward zero, magnitude clamped
  function automatic longint scale_dir(longint unsigned t, longint dv);
    longint unsigned m = dv < 0 ? longint'(-dv) : dv;
    longint unsigned q = (t * m) >> 16;
    if (q > PROD_CAP) q = PROD_CAP;
    return dv < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic isect_t predict_isect(ray_t r);
    isect_t res = '{default: '0};
    longint o[3], d[3], p[3], num, den, a, b;
    longint unsigned un, ud, q0, t;
    int ia, ib, ic;
    for (int k = 0; k < 3; k++) begin
      o[k] = sx(r.org[k]);
      d[k] = sx(r.dir[k]);
    end
    case (rect_axes)
      rair_pkg::AXIS_XY: begin ia = 0; ib = 1; ic = 2; end
      rair_pkg::AXIS_XZ: begin ia = 0; ib = 2; ic = 1; end
      rair_pkg::AXIS_YZ: begin ia = 1; ib = 2; ic = 0; end
      default: return res;
    endcase
    num = rect_plane - o[ic];
    den = d[ic];
    if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return res;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q0 = un / ud;
    if (q0 > (TMAX_MASK >> 16)) return res;
    t = (q0 << 16) | frac_bits(un % ud, ud, 16);
    if (t == 0 || t > TMAX_MASK || t >= longint'(r.max_dist)) return res;
    for (int k = 0; k < 3; k++) p[k] = o[k] + scale_dir(t, d[k]);
    a = p[ia];
    b = p[ib];
    res.occluded = a >= rect_a_lo && a <= rect_a_hi && b >= rect_b_lo && b <= rect_b_hi;
    if (!(a > rect_a_lo && a < rect_a_hi && b > rect_b_lo && b < rect_b_hi)) return res;
    res.hit = 1'b1;
    res.t_hit = t[30:0];
    res.hx = p[0][31:0];
    res.hy = p[1][31:0];
    res.hz = p[2][31:0];
    res.u = 16'(frac_bits(a - rect_a_lo, rect_a_hi - rect_a_lo, 16));
    res.v = 16'(frac_bits(b - rect_b_lo, rect_b_hi - rect_b_lo, 16));
    return res;
  endfunction

  // result checker: every done word must match the oldest prediction
  isect_t want, got;
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      got = '{hit_o, occluded_o, t_hit_o, hit_x_o, hit_y_o, hit_z_o, coord_u_o, coord_v_o};
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result word with nothing pending");
      end else begin
        want = pending_q.pop_front();
        hits_seen += want.hit;
        occl_seen += want.occluded;
        if (got != want) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: exp hit=%0b occ=%0b t=%h p=%h,%h,%h uv=%h,%h",
                     want.hit, want.occluded, want.t_hit, want.hx, want.hy, want.hz,
                     want.u, want.v);
            $display("       got hit=%0b occ=%0b t=%h p=%h,%h,%h uv=%h,%h",
                     got.hit, got.occluded, got.t_hit, got.hx, got.hy, got.hz,
                     got.u, got.v);
          end
        end
      end
    end
  end

  task automatic send_ray(ray_t r);
    start_i    <= 1'b1;
    origin_x_i <= r.org[0];
    origin_y_i <= r.org[1];
    origin_z_i <= r.org[2];
    dir_x_i    <= r.dir[0];
    dir_y_i    <= r.dir[1];
    dir_z_i    <= r.dir[2];
    max_dist_i <= r.max_dist;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_q = {pending_q, predict_isect(r)};
    rays_sent++;
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // hold off until every pending word is back, then let the pipe empty
  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [rair_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      rair_pkg::REG_AXIS_PAIR:   rect_axes  = val[1:0];
      rair_pkg::REG_FIRST_LOW:   rect_a_lo  = sx(val);
      rair_pkg::REG_FIRST_HIGH:  rect_a_hi  = sx(val);
      rair_pkg::REG_SECOND_LOW:  rect_b_lo  = sx(val);
      rair_pkg::REG_SECOND_HIGH: rect_b_hi  = sx(val);
      rair_pkg::REG_PLANE_OFS:   rect_plane = sx(val);
      default: ;
    endcase
  endtask

  task automatic set_rect(logic [1:0] axes, logic [31:0] alo, ahi, blo, bhi, plane);
    write_reg(rair_pkg::REG_AXIS_PAIR, {30'd0, axes});
    write_reg(rair_pkg::REG_FIRST_LOW, alo);
    write_reg(rair_pkg::REG_FIRST_HIGH, ahi);
    write_reg(rair_pkg::REG_SECOND_LOW, blo);
    write_reg(rair_pkg::REG_SECOND_HIGH, bhi);
    write_reg(rair_pkg::REG_PLANE_OFS, plane);
  endtask

  function automatic ray_t mk_ray(longint ox, oy, oz, dx, dy, dz, longint md);
    ray_t r;
    r.org = {oz[31:0], oy[31:0], ox[31:0]};
    r.dir = {dz[31:0], dy[31:0], dx[31:0]};
    r.max_dist = md[30:0];
    return r;
  endfunction

  // ray built to cross the plane at an integer t near or inside the rectangle
  function automatic ray_t aimed_ray();
    ray_t r;
    longint pt[3], dv[3], s, span;
    int ia, ib, ic;
    case (rect_axes)
      rair_pkg::AXIS_XZ: begin ia = 0; ib = 2; ic = 1; end
      rair_pkg::AXIS_YZ: begin ia = 1; ib = 2; ic = 0; end
      default: begin ia = 0; ib = 1; ic = 2; end
    endcase
    s = $urandom_range(1, 4);
    span = rect_a_hi - rect_a_lo;
    case ($urandom_range(0, 9))
      0: pt[ia] = rect_a_lo;
      1: pt[ia] = rect_a_hi;
      2: pt[ia] = rect_a_lo - $urandom_range(1, 65536);
      default: pt[ia] = span > 0 ? rect_a_lo + longint'({$urandom, $urandom}) % span
                                 : rect_a_lo;
    endcase
    span = rect_b_hi - rect_b_lo;
    case ($urandom_range(0, 9))
      0: pt[ib] = rect_b_lo;
      1: pt[ib] = rect_b_hi;
      2: pt[ib] = rect_b_hi + $urandom_range(1, 65536);
      default: pt[ib] = span > 0 ? rect_b_lo + longint'({$urandom, $urandom}) % span
                                 : rect_b_lo;
    endcase
    pt[ic] = rect_plane;
    for (int k = 0; k < 3; k++) begin
      dv[k] = longint'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      if ($urandom_range(0, 3) == 0) dv[k] = dv[k] * 256 + $urandom_range(0, 255);
    end
    if (dv[ic] == 0) dv[ic] = 1;
    for (int k = 0; k < 3; k++) pt[k] = pt[k] - s * dv[k];
    r = mk_ray(pt[0], pt[1], pt[2], dv[0], dv[1], dv[2], 0);
    case ($urandom_range(0, 5))
      0: r.max_dist = 31'(s * 65536 + $urandom_range(0, 2) - 1);
      1: r.max_dist = 31'($urandom);
      default: r.max_dist = 31'h7FFF_FFFF - 31'($urandom_range(0, 1000));
    endcase
    return r;
  endfunction

  // bursty random stream: mostly aimed rays, some raw noise
  task automatic random_rays(int count);
    ray_t r;
    int burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
        burst = $urandom_range(1, 30);
      end
      burst--;
      if ($urandom_range(0, 4) == 0)
        r = '{org: {$urandom, $urandom, $urandom}, dir: {$urandom, $urandom, $urandom},
              max_dist: 31'($urandom)};
      else
        r = aimed_ray();
      send_ray(r);
    end
    drain();
  endtask

  task automatic test_directed_reset_rect;
    // unit square in z = 0 at reset
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 32'h7FFF_FFFF));    // center hit
    send_ray(mk_ray(0, 32768, 65536, 0, 0, -65536, 32'h7FFF_FFFF));        // edge: occluded only
    send_ray(mk_ray(65536, 65536, 65536, 0, 0, -65536, 32'h7FFF_FFFF));    // corner
    send_ray(mk_ray(32768, 32768, 65536, 1000, 0, 0, 32'h7FFF_FFFF));      // zero normal dir
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, 65536, 32'h7FFF_FFFF));     // pointing away
    send_ray(mk_ray(32768, 32768, 0, 0, 0, -65536, 32'h7FFF_FFFF));        // origin on plane
    send_ray(mk_ray(32768, 32768, 32'h7FFF_FFFF, 0, 0, -1, 32'h7FFF_FFFF)); // quotient overflow
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 65536));            // t equals limit
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 0));                // zero limit
    send_ray(mk_ray(32768, 32768, 65536, 32'h7FFF_FFFF, 0, -65536, 32'h7FFF_FFFF));
    send_ray(mk_ray(32768, 32768, 65536, 32'h8000_0000, 32'h8000_0000, -65536,
                    32'h7FFF_FFFF));                                       // most negative x and y directions
    send_ray(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));         // field extremes
    send_ray(mk_ray(32768, 32768, 1, 0, 0, -32'h7FFF_FFFF, 32'h7FFF_FFFF)); // t truncates to 0
    send_ray(mk_ray(16384, 49152, 131072, 8192, -8192, -65536, 32'h7FFF_FFFF));
    drain();
    // unused axis code, then inverted bounds
    write_reg(rair_pkg::REG_AXIS_PAIR, 32'd3);
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 32'h7FFF_FFFF));
    drain();
    set_rect(rair_pkg::AXIS_XY, 65536, 0, 65536, 0, 0);
    send_ray(mk_ray(32768, 32768, 65536, 0, 0, -65536, 32'h7FFF_FFFF));
    send_ray(mk_ray(0, 0, 65536, 0, 0, -65536, 32'h7FFF_FFFF));
    drain();
  endtask

  task automatic test_rect_settings;
    set_rect(rair_pkg::AXIS_XY, 0, 65536, 0, 65536, 0);
    random_rays(290);
    set_rect(rair_pkg::AXIS_XZ, -32'sd655360, 32'sd3276800, 32'sd65536, 32'sd1310720,
             32'sd196608);
    random_rays(290);
    set_rect(rair_pkg::AXIS_YZ, -32'sd65536, 32'sd65536, -32'sd6553600, -32'sd131072,
             -32'sd4587520);
    random_rays(290);
    set_rect(rair_pkg::AXIS_XY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF);
    random_rays(290);
    set_rect(rair_pkg::AXIS_XZ, 32'h7FFF_FFFF, 32'h8000_0000, 32'h100, 32'h100,
             32'h8000_0000);
    random_rays(150);
    write_reg(rair_pkg::REG_AXIS_PAIR, 32'd3);
    random_rays(140);
    set_rect(2'($urandom_range(0, 2)), -$urandom_range(0, 32'h7F_FFFF),
             $urandom_range(1, 32'h7F_FFFF), -$urandom_range(0, 32'h7F_FFFF),
             $urandom_range(1, 32'h7F_FFFF), $urandom);
    random_rays(290);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_reset_rect();
    test_rect_settings();
    $display("Sent %0d rays over 10 rectangle setups; %0d results, %0d hits, %0d occluded.",
             rays_sent, results_seen, hits_seen, occl_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout");
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rair_pkg.sv
rtl/rair_divpipe.sv
rtl/rair_point.sv
rtl/ray_axis_rect_intersect_top.sv
test/ray_axis_rect_intersect_top_tb.sv
